// ----- rtl/grouped_bitmap_run_allocator_defines.svh -----
// Assertion macros shared by the allocator's checker.
// No dependencies; include by bare file name.
`ifndef GROUPED_BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define GROUPED_BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define GBRA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication, off during reset
`define GBRA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// ----- rtl/gbra_pkg.sv -----
// Types and codes for the grouped bitmap run allocator.
// No dependencies.
package gbra_pkg;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_DOUBLE   = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	localparam logic [1:0] REG_GROUPS_IN_USE    = 2'd0;
	localparam logic [1:0] REG_BLOCKS_PER_GROUP = 2'd1;
	localparam logic [1:0] REG_FIRST_DATA_BLOCK = 2'd2;

	typedef struct packed {
		logic        op;
		logic [3:0]  run_length;
		logic [3:0]  start_group;
		logic [16:0] free_block;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [16:0] first_block;
		logic [3:0]  chosen_group;
		logic [10:0] group_free;
	} rsp_t;

endpackage

// ----- rtl/grouped_bitmap_run_allocator.sv -----
// Grouped bitmap run allocator: first-fit runs from per-group bitmaps, single-block free.
// Depends on gbra_pkg.
//
// Free runs a restoring divide, then one word read.
// Allocate walks the bitmap memory one bit a cycle while a word is held, skipping all-used
// word tails, with read and capture states per word fetched; a found run is checked, then marked.
// One item at a time; next item accepted once the result is registered.
// Reset: counts and config go to reset values at once; then a clearing pass zeroes every
// bitmap word with req_stall high.
module grouped_bitmap_run_allocator import gbra_pkg::*; #(
	parameter int GROUPS         = 16,
	parameter int BITS_PER_GROUP = 1024,
	parameter int MAX_RUN        = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// bitmap geometry: 32-bit words, linear bit address g*BITS_PER_GROUP + b
	localparam int W     = 32;
	localparam int LW    = 5;
	localparam int TOTAL = GROUPS * BITS_PER_GROUP;
	localparam int DEPTH = (TOTAL + W - 1) / W;
	localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW    = $clog2(TOTAL) + 1;
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int PW    = 13;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_GROUP = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_FCHK  = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_CAP   = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_FIN1  = 4'd8;
	localparam logic [3:0] S_FIN2  = 4'd9;
	localparam logic [3:0] S_POST  = 4'd10;

	// scan modes
	localparam logic [1:0] M_SEARCH = 2'd0;
	localparam logic [1:0] M_CHECK  = 2'd1;
	localparam logic [1:0] M_MARK   = 2'd2;
	localparam logic [1:0] M_FREE   = 2'd3;

	logic [3:0]     state_q;
	logic [1:0]     mode_q;
	logic [4:0]     cfg_groups_q;
	logic [10:0]    cfg_bpg_q;
	logic [15:0]    cfg_fdb_q;
	logic [10:0]    used_q [GROUPS];

	logic           op_q;
	logic [3:0]     len_q;
	logic [GW-1:0]  g_q;
	logic [8:0]     n_q;
	logic [AW-1:0]  base_q;
	logic [PW-1:0]  p_q, s_q, e_q;
	logic [W-1:0]   cur_q;
	logic [WAW-1:0] wa_q;
	logic [16:0]    dvd_q;
	logic [11:0]    rem_q;
	logic [4:0]     cnt_q;
	logic [1:0]     stat_q;
	logic [18:0]    prod_q;
	logic [WAW:0]   clr_q;
	rsp_t           res_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;

	// bitmap memory
	logic [W-1:0]   mem [DEPTH];
	logic [W-1:0]   rdata;
	logic           mem_we;
	logic [WAW-1:0] mem_wa, mem_ra;
	logic [W-1:0]   mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata <= mem[mem_ra];
	end

	// effective config
	logic [8:0]  ng;
	logic [10:0] bpg;
	always_comb begin
		if (cfg_groups_q == 5'd0) begin
			ng = 9'd1;
		end else if ({4'b0, cfg_groups_q} > 9'(GROUPS)) begin
			ng = 9'(GROUPS);
		end else begin
			ng = {4'b0, cfg_groups_q};
		end
		if ({5'b0, cfg_bpg_q} > 16'(BITS_PER_GROUP)) begin
			bpg = 11'(BITS_PER_GROUP);
		end else begin
			bpg = cfg_bpg_q;
		end
	end

	// current group bookkeeping
	logic [10:0]   used_g, free_g;
	logic [8:0]    gp1;
	logic [GW-1:0] g_nxt;
	assign used_g = used_q[g_q];
	assign free_g = (used_g >= bpg) ? 11'd0 : (bpg - used_g);
	assign gp1    = 9'(g_q) + 9'd1;
	assign g_nxt  = (gp1 == ng) ? '0 : GW'(gp1);

	// bit position under scan
	logic [AW-1:0]  abs_bit;
	logic [WAW-1:0] word_idx;
	logic [LW-1:0]  off;
	logic           cur_bit, ones_above;
	logic [W-1:0]   bit_mask;
	logic [PW-1:0]  e_new;
	assign abs_bit    = base_q + AW'(p_q);
	assign word_idx   = WAW'(abs_bit >> LW);
	assign off        = abs_bit[LW-1:0];
	assign bit_mask   = W'(1) << off;
	assign cur_bit    = cur_q[off];
	assign ones_above = &(cur_q | (bit_mask - W'(1)));
	assign e_new      = p_q + PW'(len_q) - PW'(1);

	// request decode
	logic [GW-1:0] hint_g;
	logic          len_ok;
	logic [16:0]   free_off;
	logic [11:0]   div_r;
	assign hint_g   = ({5'b0, req.start_group} < ng) ? GW'(req.start_group) : '0;
	assign len_ok   = (req.run_length != 4'd0) && (7'(req.run_length) <= 7'(MAX_RUN));
	assign free_off = req.free_block - {1'b0, cfg_fdb_q} - 17'd1;
	assign div_r    = {rem_q[10:0], dvd_q[16]};

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = wa_q;
		mem_wd = cur_q;
		mem_ra = word_idx;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q[WAW-1:0];
			mem_wd = '0;
		end else if (state_q == S_SCAN) begin
			if (mode_q == M_MARK && word_idx != wa_q) begin
				mem_we = 1'b1;
			end else if (mode_q == M_MARK && p_q == e_q) begin
				mem_we = 1'b1;
				mem_wd = cur_q | bit_mask;
			end else if (mode_q == M_FREE && cur_bit) begin
				mem_we = 1'b1;
				mem_wd = cur_q & ~bit_mask;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			rsp_valid_q  <= 1'b0;
			cfg_groups_q <= 5'd16;
			cfg_bpg_q    <= 11'd1024;
			cfg_fdb_q    <= 16'd0;
			for (int i = 0; i < GROUPS; i++) begin
				used_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GROUPS_IN_USE:    cfg_groups_q <= cfg_data[4:0];
					REG_BLOCKS_PER_GROUP: cfg_bpg_q    <= cfg_data[10:0];
					REG_FIRST_DATA_BLOCK: cfg_fdb_q    <= cfg_data;
					default: ;
				endcase
			end
			// S_POST reloads the output itself
			if (rsp_valid_q && !rsp_stall && state_q != S_POST) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (WAW+1)'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= req.op;
						len_q <= req.run_length;
						if (req.op == OP_ALLOC) begin
							g_q <= hint_g;
							n_q <= '0;
							if (len_ok) begin
								res_q   <= '0;
								state_q <= S_GROUP;
							end else begin
								res_q   <= {ST_NO_SPACE, 32'd0};
								state_q <= S_POST;
							end
						end else if (req.free_block > {1'b0, cfg_fdb_q} && bpg != 11'd0) begin
							res_q   <= '0;
							dvd_q   <= free_off;
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_DIV;
						end else begin
							res_q   <= {ST_RANGE, 32'd0};
							state_q <= S_POST;
						end
					end
				end
				S_GROUP: begin
					if (n_q == ng) begin
						res_q.status <= ST_NO_SPACE;
						state_q      <= S_POST;
					end else if (free_g >= 11'(len_q)) begin
						base_q  <= AW'(g_q * BITS_PER_GROUP);
						p_q     <= '0;
						mode_q  <= M_SEARCH;
						state_q <= S_RD;
					end else begin
						g_q <= g_nxt;
						n_q <= n_q + 9'd1;
					end
				end
				// restoring divide: quotient shifts into dvd_q
				S_DIV: begin
					if (div_r >= {1'b0, bpg}) begin
						rem_q <= div_r - {1'b0, bpg};
						dvd_q <= {dvd_q[15:0], 1'b1};
					end else begin
						rem_q <= div_r;
						dvd_q <= {dvd_q[15:0], 1'b0};
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (dvd_q >= {8'b0, ng}) begin
						res_q.status <= ST_RANGE;
						state_q      <= S_POST;
					end else begin
						g_q     <= GW'(dvd_q);
						base_q  <= AW'(GW'(dvd_q) * BITS_PER_GROUP);
						p_q     <= PW'(rem_q);
						mode_q  <= M_FREE;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					wa_q    <= word_idx;
					state_q <= S_CAP;
				end
				S_CAP: begin
					cur_q   <= rdata;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (mode_q != M_FREE && mode_q != M_MARK && p_q >= PW'(bpg)) begin
						// group exhausted
						g_q     <= g_nxt;
						n_q     <= n_q + 9'd1;
						state_q <= S_GROUP;
					end else if (word_idx != wa_q) begin
						state_q <= S_RD;
					end else begin
						case (mode_q)
							M_SEARCH: begin
								if (cur_bit) begin
									if (ones_above) begin
										p_q <= p_q + PW'(W) - PW'(off);
									end else begin
										p_q <= p_q + PW'(1);
									end
								end else if (e_new >= PW'(bpg)) begin
									g_q     <= g_nxt;
									n_q     <= n_q + 9'd1;
									state_q <= S_GROUP;
								end else begin
									s_q    <= p_q;
									e_q    <= e_new;
									mode_q <= M_CHECK;
								end
							end
							M_CHECK: begin
								if (cur_bit) begin
									p_q    <= e_q + PW'(1);
									mode_q <= M_SEARCH;
								end else if (p_q == e_q) begin
									p_q    <= s_q;
									mode_q <= M_MARK;
								end else begin
									p_q <= p_q + PW'(1);
								end
							end
							M_MARK: begin
								cur_q <= cur_q | bit_mask;
								if (p_q == e_q) begin
									stat_q  <= ST_OK;
									state_q <= S_FIN1;
								end else begin
									p_q <= p_q + PW'(1);
								end
							end
							default: begin
								stat_q  <= cur_bit ? ST_OK : ST_DOUBLE;
								state_q <= S_FIN1;
							end
						endcase
					end
				end
				S_FIN1: begin
					if (stat_q == ST_OK) begin
						if (op_q == OP_ALLOC) begin
							used_q[g_q] <= used_g + 11'(len_q);
						end else if (used_g != 11'd0) begin
							used_q[g_q] <= used_g - 11'd1;
						end
					end
					prod_q  <= 19'(g_q) * 19'(bpg);
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					res_q.status       <= stat_q;
					res_q.chosen_group <= 4'(g_q);
					res_q.group_free   <= free_g;
					if (op_q == OP_ALLOC) begin
						res_q.first_block <= 17'({4'b0, cfg_fdb_q} + 20'd1 + 20'(prod_q)
							+ 20'(s_q));
					end else begin
						res_q.first_block <= '0;
					end
					state_q <= S_POST;
				end
				S_POST: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/gbra_checker.sv -----
// Port-level checks for the grouped bitmap run allocator, bound to the top level.
// Depends on gbra_pkg and grouped_bitmap_run_allocator_defines.svh.
`include "grouped_bitmap_run_allocator_defines.svh"

module gbra_checker import gbra_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input rsp_t        rsp
);

	// one item in flight: busy right after an accept
	`GBRA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

	// failures carry no block, group or count
	`GBRA_ASSERT_NOW(a_fail_zero,
		rsp_valid && (rsp.status == ST_NO_SPACE || rsp.status == ST_RANGE),
		rsp.first_block == 17'd0 && rsp.chosen_group == 4'd0 && rsp.group_free == 11'd0)

	// double free reports no block
	`GBRA_ASSERT_NOW(a_double_no_block, rsp_valid && rsp.status == ST_DOUBLE, rsp.first_block == 17'd0)

	// stalled item holds
	`GBRA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind grouped_bitmap_run_allocator gbra_checker u_gbra_checker (.*);
